// ----- src/hcr_pkg.sv -----
// Shared constants and control types for the Harris corner response unit.
`default_nettype none
package hcr_pkg;

   // Size limits and register reset values
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int K_W          = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_K_Q16        = 2'd2;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd752;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [K_W-1:0]          K_RESET      = 15'd2621;
   localparam int MIN_SIZE = 5;

   // Datapath widths
   localparam int PIX_W    = 8;
   localparam int GRAD_W   = 11;
   localparam int XX_W     = 20;
   localparam int XY_W     = 21;
   localparam int PROD_W   = 2 * XX_W + XY_W;
   localparam int SUM_U_W  = 24;
   localparam int SUM_S_W  = 25;
   localparam int RESP_W   = 48;
   localparam int COL_OUT_W = 10;
   localparam int ROW_OUT_W = 12;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic grad_en;
      logic row_odd;
   } pix_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic prod_en;
      logic wr_en;
      logic sum_en;
      logic row_odd;
   } prod_ctl_type;

endpackage
`default_nettype wire

// ----- src/hcr_pixel_stage.sv -----
// Pixel line memory, 3x3 pixel window and Sobel gradients.
`default_nettype none
module hcr_pixel_stage #(
   parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire hcr_pkg::pix_ctl_type                   ctl,
   input  wire logic [COL_W-1:0]                       col,
   input  wire logic [hcr_pkg::PIX_W-1:0]              pixel,
   output logic signed [hcr_pkg::GRAD_W-1:0]           gx,
   output logic signed [hcr_pkg::GRAD_W-1:0]           gy
);
   localparam int PW = hcr_pkg::PIX_W;

   // one entry holds the even-row and odd-row pixel of a column
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_data_ff;
   logic [2*PW-1:0] wr_entry;
   logic [PW-1:0]   win_ff [3][3];
   logic [PW-1:0]   win_in [3][3];
   logic [PW-1:0]   line_a, line_b;
   logic signed [hcr_pkg::GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [hcr_pkg::GRAD_W:0]   gx_sum, gy_sum;

   always_comb begin
      line_a   = ctl.row_odd ? rd_data_ff[2*PW-1:PW] : rd_data_ff[PW-1:0];
      line_b   = ctl.row_odd ? rd_data_ff[PW-1:0] : rd_data_ff[2*PW-1:PW];
      wr_entry = ctl.row_odd ? {pixel, rd_data_ff[PW-1:0]} : {rd_data_ff[2*PW-1:PW], pixel};
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= line_mem[col];
      end
      if (ctl.wr_en) begin
         line_mem[col] <= wr_entry;
      end
   end

   always_comb begin
      win_in = win_ff;
      if (ctl.wr_en) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = line_a;
         win_in[1][2] = line_b;
         win_in[2][2] = pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      gx_sum = $signed({4'b0, win_ff[0][2]}) + $signed({3'b0, win_ff[1][2], 1'b0})
             + $signed({4'b0, win_ff[2][2]}) - $signed({4'b0, win_ff[0][0]})
             - $signed({3'b0, win_ff[1][0], 1'b0}) - $signed({4'b0, win_ff[2][0]});
      gy_sum = $signed({4'b0, win_ff[2][0]}) + $signed({3'b0, win_ff[2][1], 1'b0})
             + $signed({4'b0, win_ff[2][2]}) - $signed({4'b0, win_ff[0][0]})
             - $signed({3'b0, win_ff[0][1], 1'b0}) - $signed({4'b0, win_ff[0][2]});
   end

   always_ff @(posedge clock) begin
      if (ctl.grad_en) begin
         gx_ff <= gx_sum[hcr_pkg::GRAD_W-1:0];
         gy_ff <= gy_sum[hcr_pkg::GRAD_W-1:0];
      end
   end

   assign gx = gx_ff;
   assign gy = gy_ff;

endmodule
`default_nettype wire

// ----- src/hcr_product_stage.sv -----
// Gradient products, product line memory, 3x3 product window and box sums.
`default_nettype none
module hcr_product_stage #(
   parameter int MAX_WIDTH = hcr_pkg::DEF_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire hcr_pkg::prod_ctl_type                 ctl,
   input  wire logic [COL_W-1:0]                      col,
   input  wire logic signed [hcr_pkg::GRAD_W-1:0]     gx,
   input  wire logic signed [hcr_pkg::GRAD_W-1:0]     gy,
   output logic [hcr_pkg::SUM_U_W-1:0]                sxx,
   output logic [hcr_pkg::SUM_U_W-1:0]                syy,
   output logic signed [hcr_pkg::SUM_S_W-1:0]         sxy
);
   localparam int PW  = hcr_pkg::PROD_W;
   localparam int XX  = hcr_pkg::XX_W;
   localparam int XY  = hcr_pkg::XY_W;
   localparam int UW  = hcr_pkg::SUM_U_W;
   localparam int SW  = hcr_pkg::SUM_S_W;

   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_data_ff;
   logic [2*PW-1:0] wr_entry;
   logic [PW-1:0]   fresh_ff;
   logic [PW-1:0]   win_ff [3][3];
   logic [PW-1:0]   win_in [3][3];
   logic [PW-1:0]   line_a, line_b;
   logic signed [2*hcr_pkg::GRAD_W-1:0] mxx, myy, mxy;
   logic [UW-1:0]         sxx_in, syy_in, sxx_ff, syy_ff;
   logic signed [SW-1:0]  sxy_in, sxy_ff;

   // fresh products land in the line of the other parity (row r-1)
   always_comb begin
      line_a   = ctl.row_odd ? rd_data_ff[PW-1:0] : rd_data_ff[2*PW-1:PW];
      line_b   = ctl.row_odd ? rd_data_ff[2*PW-1:PW] : rd_data_ff[PW-1:0];
      wr_entry = ctl.row_odd ? {rd_data_ff[2*PW-1:PW], fresh_ff}
                             : {fresh_ff, rd_data_ff[PW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= line_mem[col];
      end
      if (ctl.wr_en) begin
         line_mem[col] <= wr_entry;
      end
   end

   always_comb begin
      mxx = gx * gx;
      myy = gy * gy;
      mxy = gx * gy;
   end

   always_ff @(posedge clock) begin
      if (ctl.prod_en) begin
         fresh_ff <= {mxy[XY-1:0], myy[XX-1:0], mxx[XX-1:0]};
      end
   end

   always_comb begin
      win_in = win_ff;
      if (ctl.wr_en) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i][0] = win_ff[i][1];
            win_in[i][1] = win_ff[i][2];
         end
         win_in[0][2] = line_a;
         win_in[1][2] = line_b;
         win_in[2][2] = fresh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      sxx_in = '0;
      syy_in = '0;
      sxy_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sxx_in = sxx_in + UW'(win_ff[i][j][XX-1:0]);
            syy_in = syy_in + UW'(win_ff[i][j][2*XX-1:XX]);
            sxy_in = sxy_in + SW'($signed(win_ff[i][j][PW-1:2*XX]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sxx_ff <= sxx_in;
         syy_ff <= syy_in;
         sxy_ff <= sxy_in;
      end
   end

   assign sxx = sxx_ff;
   assign syy = syy_ff;
   assign sxy = sxy_ff;

endmodule
`default_nettype wire

// ----- src/hcr_response_calc.sv -----
// Four-stage det - k*trace^2 pipeline with 48-bit saturation.
`default_nettype none
module hcr_response_calc (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [hcr_pkg::SUM_U_W-1:0]          sxx,
   input  wire logic [hcr_pkg::SUM_U_W-1:0]          syy,
   input  wire logic signed [hcr_pkg::SUM_S_W-1:0]   sxy,
   input  wire logic [hcr_pkg::K_W-1:0]              k_q16,
   output logic                                      done,
   output logic signed [hcr_pkg::RESP_W-1:0]         response
);
   localparam int UW  = hcr_pkg::SUM_U_W;
   localparam int TW  = UW + 1;             // trace
   localparam int T2W = 2 * TW;             // trace squared
   localparam int HW  = T2W / 2;            // half of trace squared
   localparam int KW  = hcr_pkg::K_W;
   localparam int PKW = HW + KW;
   localparam int RW  = hcr_pkg::RESP_W;
   localparam int KTW = T2W + KW - 16;      // floored k*tr^2
   localparam int DW  = RW + 3;

   logic [3:0]             valid_ff, valid_in;
   logic [2*UW-1:0]        p1_ff;
   logic signed [2*hcr_pkg::SUM_S_W-1:0] p2_full;
   logic [2*UW-1:0]        p2_ff;
   logic [TW-1:0]          tr;
   logic [T2W-1:0]         tr2_ff;
   logic signed [2*UW:0]   det_ff, det2_ff;
   logic [PKW-1:0]         hk_ff, lk_ff;
   logic [T2W+KW-1:0]      ktr_full;
   logic [KTW-1:0]         ktr_ff;
   logic signed [DW-1:0]   diff;
   logic signed [RW-1:0]   resp_ff, resp_in;

   assign valid_in = {valid_ff[2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      tr      = TW'(sxx) + TW'(syy);
      p2_full = sxy * sxy;
   end

   // stage 1: the three products
   always_ff @(posedge clock) begin
      p1_ff  <= sxx * syy;
      p2_ff  <= p2_full[2*UW-1:0];
      tr2_ff <= tr * tr;
   end

   // stage 2: determinant, k times each half of tr^2
   always_ff @(posedge clock) begin
      det_ff <= $signed({1'b0, p1_ff}) - $signed({1'b0, p2_ff});
      hk_ff  <= tr2_ff[T2W-1:HW] * k_q16;
      lk_ff  <= tr2_ff[HW-1:0] * k_q16;
   end

   // stage 3: recombine and floor
   assign ktr_full = ((T2W + KW)'(hk_ff) << HW) + (T2W + KW)'(lk_ff);

   always_ff @(posedge clock) begin
      ktr_ff  <= ktr_full[T2W+KW-1:16];
      det2_ff <= det_ff;
   end

   // stage 4: subtract and clamp to 48 bits
   always_comb begin
      diff = DW'(det2_ff) - $signed({1'b0, (DW-1)'(ktr_ff)});
      if (diff[DW-1] == 1'b0 && diff[DW-2:RW-1] != '0) begin
         resp_in = {1'b0, {(RW-1){1'b1}}};
      end else if (diff[DW-1] == 1'b1 && diff[DW-2:RW-1] != '1) begin
         resp_in = {1'b1, {(RW-1){1'b0}}};
      end else begin
         resp_in = diff[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      resp_ff <= resp_in;
   end

   assign done     = valid_ff[3];
   assign response = resp_ff;

endmodule
`default_nettype wire

// ----- src/harris_corner_response_unit.sv -----
// Top level: raster position, sequencer, config registers and result register.
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+--------------------------------------
//  req     | in  | req_valid/req_ready   | pixel, frame_start
//  rsp     | out | rsp_valid/rsp_ready   | response, center_col, center_row, last
//  csr     | in  | csr_we (no wait)      | csr_index, csr_wdata
//
//  One pixel word is in flight at a time. A border pixel goes through the pixel
//  read-modify-write and Sobel steps, one that only feeds the product lines also the
//  product steps, and one that yields a response also the four-stage multiplier chain.
//  Reset is synchronous; it clears the sequencer, positions and windows and reloads config.
//  A response waiting in the result register does not block the next pixel; the
//  sequencer stalls only at its last step if the result register is still full.
`default_nettype none
module harris_corner_response_unit #(
   parameter int MAX_WIDTH  = hcr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = hcr_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [hcr_pkg::PIX_W-1:0]            req_pixel,
   input  wire logic                                 req_frame_start,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [hcr_pkg::RESP_W-1:0]         rsp_response,
   output logic [hcr_pkg::COL_OUT_W-1:0]             rsp_center_col,
   output logic [hcr_pkg::ROW_OUT_W-1:0]             rsp_center_row,
   output logic                                      rsp_frame_last,
   input  wire logic                                 csr_we,
   input  wire logic [hcr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [hcr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WU_W  = $clog2(MAX_WIDTH + 1);
   localparam int HU_W  = $clog2(MAX_HEIGHT + 1);

   // sequencer codes
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;   // line memory data back, pixel write
   localparam logic [3:0] ST_GRAD = 4'd2;   // Sobel into registers
   localparam logic [3:0] ST_PROD = 4'd3;   // gradient products
   localparam logic [3:0] ST_PWR  = 4'd4;   // product line write, window shift
   localparam logic [3:0] ST_SUM  = 4'd5;   // 3x3 box sums
   localparam logic [3:0] ST_CALC = 4'd6;   // launch response pipeline
   localparam logic [3:0] ST_WAIT = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;   // load result register

   logic [3:0] state_ff, state_in;

   // config registers
   logic [hcr_pkg::WIDTH_REG_W-1:0]  image_width_ff;
   logic [hcr_pkg::HEIGHT_REG_W-1:0] image_height_ff;
   logic [hcr_pkg::K_W-1:0]          k_q16_ff;
   logic [WU_W-1:0] w_use;
   logic [HU_W-1:0] h_use;

   // raster position
   logic [COL_W-1:0] col_ff, col_in, c0, c_pre, cur_c_ff;
   logic [ROW_W-1:0] row_ff, row_in, r0, r_pre, cur_r_ff;
   logic [ROW_W:0]   r1;
   logic             wrap_c;
   logic             accept;
   logic             gate2_ff, gate4_ff, last_ff;
   localparam int PIX_W_L = hcr_pkg::PIX_W;
   logic [PIX_W_L-1:0] pix_ff;

   logic [COL_W-1:0] addr_col;
   logic             addr_odd;
   hcr_pkg::pix_ctl_type  pix_ctl;
   hcr_pkg::prod_ctl_type prod_ctl;
   logic signed [hcr_pkg::GRAD_W-1:0] gx, gy;
   logic [hcr_pkg::SUM_U_W-1:0]        sxx, syy;
   logic signed [hcr_pkg::SUM_S_W-1:0] sxy;
   logic                               calc_done;
   logic signed [hcr_pkg::RESP_W-1:0]  calc_resp;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in, rsp_load;
   logic signed [hcr_pkg::RESP_W-1:0]   rsp_response_ff;
   logic [hcr_pkg::COL_OUT_W-1:0]       rsp_col_ff;
   logic [hcr_pkg::ROW_OUT_W-1:0]       rsp_row_ff;
   logic                                rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= hcr_pkg::WIDTH_RESET;
         image_height_ff <= hcr_pkg::HEIGHT_RESET;
         k_q16_ff        <= hcr_pkg::K_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            hcr_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[hcr_pkg::WIDTH_REG_W-1:0];
            end
            hcr_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[hcr_pkg::HEIGHT_REG_W-1:0];
            end
            hcr_pkg::CSR_K_Q16: begin
               k_q16_ff <= csr_wdata[hcr_pkg::K_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // frame size clamped to [5, MAX]
   always_comb begin
      if (32'(image_width_ff) < 32'(hcr_pkg::MIN_SIZE)) begin
         w_use = WU_W'(hcr_pkg::MIN_SIZE);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         w_use = WU_W'(MAX_WIDTH);
      end else begin
         w_use = WU_W'(image_width_ff);
      end
      if (32'(image_height_ff) < 32'(hcr_pkg::MIN_SIZE)) begin
         h_use = HU_W'(hcr_pkg::MIN_SIZE);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         h_use = HU_W'(MAX_HEIGHT);
      end else begin
         h_use = HU_W'(image_height_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // position of the incoming word, after any pending wrap
   always_comb begin
      c0     = req_frame_start ? '0 : col_ff;
      r0     = req_frame_start ? '0 : row_ff;
      wrap_c = 32'(c0) >= 32'(w_use);
      c_pre  = wrap_c ? '0 : c0;
      r1     = wrap_c ? (ROW_W + 1)'(r0) + 1'b1 : (ROW_W + 1)'(r0);
      r_pre  = (32'(r1) >= 32'(h_use)) ? '0 : r1[ROW_W-1:0];
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (32'(c_pre) + 32'd1 >= 32'(w_use)) begin
            col_in = '0;
            row_in = (32'(r_pre) + 32'd1 >= 32'(h_use)) ? '0 : r_pre + 1'b1;
         end else begin
            col_in = c_pre + 1'b1;
            row_in = r_pre;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_c_ff <= c_pre;
         cur_r_ff <= r_pre;
         pix_ff   <= req_pixel;
         gate2_ff <= (32'(c_pre) >= 32'd2) && (32'(r_pre) >= 32'd2);
         gate4_ff <= (32'(c_pre) >= 32'd4) && (32'(r_pre) >= 32'd4);
         last_ff  <= (32'(c_pre) + 32'd1 == 32'(w_use))
                  && (32'(r_pre) + 32'd1 == 32'(h_use));
      end
   end

   // memories are read in the accept cycle, so address straight from the port side
   always_comb begin
      addr_col = (state_ff == ST_IDLE) ? c_pre : cur_c_ff;
      addr_odd = (state_ff == ST_IDLE) ? r_pre[0] : cur_r_ff[0];

      pix_ctl.rd_en   = accept;
      pix_ctl.wr_en   = (state_ff == ST_READ);
      pix_ctl.grad_en = (state_ff == ST_GRAD);
      pix_ctl.row_odd = addr_odd;

      prod_ctl.rd_en   = accept;
      prod_ctl.prod_en = (state_ff == ST_PROD);
      prod_ctl.wr_en   = (state_ff == ST_PWR);
      prod_ctl.sum_en  = (state_ff == ST_SUM);
      prod_ctl.row_odd = addr_odd;
   end

   hcr_pixel_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_pixel (
      .clock  (clock),
      .reset  (reset),
      .ctl    (pix_ctl),
      .col    (addr_col),
      .pixel  (pix_ff),
      .gx     (gx),
      .gy     (gy)
   );

   // gradient belongs to the column one to the left
   hcr_product_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_product (
      .clock  (clock),
      .reset  (reset),
      .ctl    (prod_ctl),
      .col    (addr_col - 1'b1),
      .gx     (gx),
      .gy     (gy),
      .sxx    (sxx),
      .syy    (syy),
      .sxy    (sxy)
   );

   hcr_response_calc u_calc (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_CALC),
      .sxx      (sxx),
      .syy      (syy),
      .sxy      (sxy),
      .k_q16    (k_q16_ff),
      .done     (calc_done),
      .response (calc_resp)
   );

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_GRAD;
         end
         ST_GRAD: begin
            state_in = gate2_ff ? ST_PROD : ST_IDLE;
         end
         ST_PROD: begin
            state_in = ST_PWR;
         end
         ST_PWR: begin
            state_in = gate4_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (calc_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // calc result holds while the box sums and k stay unchanged, so ST_OUT may wait on it
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_response_ff <= calc_resp;
         rsp_col_ff      <= hcr_pkg::COL_OUT_W'(cur_c_ff - COL_W'(2));
         rsp_row_ff      <= hcr_pkg::ROW_OUT_W'(cur_r_ff - ROW_W'(2));
         rsp_last_ff     <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_response   = rsp_response_ff;
   assign rsp_center_col = rsp_col_ff;
   assign rsp_center_row = rsp_row_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule
`default_nettype wire

// ----- src/hcr_port_checker.sv -----
// Port-level assertions for the Harris corner response unit, bound to the top level.
`default_nettype none
module hcr_port_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [hcr_pkg::COL_OUT_W-1:0]        rsp_center_col,
   input wire logic [hcr_pkg::ROW_OUT_W-1:0]        rsp_center_row
);
   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // one word at a time: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pixel word accepted while another is in flight");

   // a new result is only loaded while the input side is busy
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while sequencer idle");

   // only interior centres are reported
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_col >= 2 && rsp_center_row >= 2)
      else $error("border centre reported");

endmodule

bind harris_corner_response_unit hcr_port_checker u_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_center_col (rsp_center_col),
   .rsp_center_row (rsp_center_row)
);
`default_nettype wire
